/* rtl/pab_pkg.sv */
// Shared widths, codes, reset values and divider handshake types of the bump allocator.
`default_nettype none
package pab_pkg;

  // Field and register widths
  localparam int PSZ_W      = 17;
  localparam int PAGES_W    = 13;
  localparam int ALIGN_W    = 13;
  localparam int SIZE_W     = 17;
  localparam int ADDR_W     = 29;
  localparam int IDX_W      = 12;
  localparam int OVF_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Internal widths: effective page size, aligned offset, page index and capacity
  localparam int DSR_W = 18;
  localparam int DVD_W = 30;
  localparam int PIX_W = 31;
  localparam int CAP_W = 31;

  // Radix-4 divider: two quotient bits per cycle
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(32'h1FFF_FFFF);

  localparam logic [PSZ_W-1:0]   PAGE_SIZE_RST = PSZ_W'(65536);
  localparam logic [PAGES_W-1:0] MAX_PAGES_RST = PAGES_W'(16);
  localparam logic [ALIGN_W-1:0] ALIGN_RST     = ALIGN_W'(256);

  localparam logic [OVF_W-1:0] OVF_SAT = '1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_SIZE = 2'd0,
    REG_MAX_PAGES = 2'd1,
    REG_ALIGN     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/pab_divider.sv */
// Radix-4 restoring divider shared by the page-size, alignment and page-index steps.
`default_nettype none
module pab_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pab_pkg::div_req_t req,
  output pab_pkg::div_rsp_t      rsp
);

  logic [pab_pkg::DSR_W-1:0] rem;
  logic [pab_pkg::DSR_W-1:0] dsr;
  logic [pab_pkg::DVD_W-1:0] quo;
  logic [pab_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;

  logic [pab_pkg::DSR_W:0]   t1, t2, d1, d2, dsr_x;
  logic                      ge1, ge2;
  logic [pab_pkg::DSR_W-1:0] r1, r2;

  // Two dependent restoring steps per cycle
  always_comb begin
    dsr_x = {1'b0, dsr};
    t1    = {rem, quo[pab_pkg::DVD_W-1]};
    d1    = t1 - dsr_x;
    ge1   = (t1 >= dsr_x);
    r1    = ge1 ? d1[pab_pkg::DSR_W-1:0] : t1[pab_pkg::DSR_W-1:0];
    t2    = {r1, quo[pab_pkg::DVD_W-2]};
    d2    = t2 - dsr_x;
    ge2   = (t2 >= dsr_x);
    r2    = ge2 ? d2[pab_pkg::DSR_W-1:0] : t2[pab_pkg::DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= pab_pkg::CNT_W'(pab_pkg::DIV_STEPS);
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= r2;
        quo <= {quo[pab_pkg::DVD_W-3:0], ge1, ge2};
        cnt <= cnt - pab_pkg::CNT_W'(1);
        if (cnt == pab_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy      = busy;
    rsp.done      = done;
    rsp.quotient  = quo;
    rsp.remainder = rem;
  end

endmodule
`default_nettype wire

/* rtl/paged_aligned_bump_allocator.sv */
// Top level of the paged bump allocator: configuration, sequencer and result register.
// Sequence: a clear word goes straight to the commit state. An allocate word takes two passes
//   of the shared radix-4 divider plus a commit state; after a configuration write, one more
//   pass and a capacity state first work out the effective page size and capacity again.
// Throughput: one word at a time; in_ready is high only while the sequencer waits, so
//   a new word is taken only after the last result has gone into the result register.
// Reset (rst, synchronous): registers to 65536 / 16 / 256, arena state and out_valid clear.
`default_nettype none
module paged_aligned_bump_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [pab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pab_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [pab_pkg::SIZE_W-1:0]     request_size,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               ok,
  output logic [pab_pkg::ADDR_W-1:0]         offset,
  output logic [pab_pkg::IDX_W-1:0]          page_index,
  output logic [pab_pkg::ADDR_W-1:0]         bytes_used,
  output logic [pab_pkg::PAGES_W-1:0]        pages_used,
  output logic [pab_pkg::ADDR_W-1:0]         high_water,
  output logic [pab_pkg::OVF_W-1:0]          overflow_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEO_DIV,
    S_GEO_CAP,
    S_ALIGN_DIV,
    S_PAGE_DIV,
    S_COMMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [pab_pkg::PSZ_W-1:0]   page_size_r;
  logic [pab_pkg::PAGES_W-1:0] max_pages_r;
  logic [pab_pkg::ALIGN_W-1:0] align_r;

  // Arena state
  logic [pab_pkg::ADDR_W-1:0]  cursor;
  logic [pab_pkg::PAGES_W-1:0] page_count;
  logic [pab_pkg::ADDR_W-1:0]  high_water_mark;
  logic [pab_pkg::OVF_W-1:0]   overflow_total;

  // Word in flight and derived geometry
  logic                        act;
  logic [pab_pkg::SIZE_W-1:0]  size;
  logic                        geo_dirty;
  logic [pab_pkg::DSR_W-1:0]   page_eff;
  logic [pab_pkg::CAP_W-1:0]   cap_prod;
  logic [pab_pkg::DVD_W-1:0]   off;
  logic [pab_pkg::PIX_W-1:0]   idx;

  // Divider handshake
  logic                        div_start;
  logic [pab_pkg::DVD_W-1:0]   div_dividend;
  logic [pab_pkg::DSR_W-1:0]   div_divisor;
  pab_pkg::div_req_t           div_req;
  pab_pkg::div_rsp_t           div_rsp;

  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = div_dividend;
    div_req.divisor  = div_divisor;
  end

  pab_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Zero-valued registers act as one
  logic [pab_pkg::PSZ_W-1:0]   p_eff;
  logic [pab_pkg::ALIGN_W-1:0] a_eff;
  logic [pab_pkg::PAGES_W-1:0] pages_eff;
  logic [pab_pkg::DSR_W-1:0]   a_ext;
  logic [pab_pkg::DSR_W-1:0]   pad;
  logic [pab_pkg::DSR_W-1:0]   page_calc;
  logic [pab_pkg::DVD_W-1:0]   aligned;
  logic                        spill;
  logic [pab_pkg::DVD_W-1:0]   off_spill;
  logic [pab_pkg::CAP_W-1:0]   blk_end;
  logic                        fail;
  logic                        slot_free;
  logic [pab_pkg::ADDR_W-1:0]  cursor_new;

  always_comb begin
    p_eff     = (page_size_r == '0) ? pab_pkg::PSZ_W'(1)   : page_size_r;
    a_eff     = (align_r == '0)     ? pab_pkg::ALIGN_W'(1) : align_r;
    pages_eff = (max_pages_r == '0) ? pab_pkg::PAGES_W'(1) : max_pages_r;
    a_ext     = pab_pkg::DSR_W'(a_eff);

    // Distance up to the next multiple of the alignment, from the divider remainder
    pad       = (div_rsp.remainder == '0) ? '0 : (a_ext - div_rsp.remainder);
    page_calc = pab_pkg::DSR_W'(p_eff) + pad;
    aligned   = pab_pkg::DVD_W'(cursor) + pab_pkg::DVD_W'(pad);

    // Block would run past the end of its page: move to the next page start
    spill     = ({1'b0, div_rsp.remainder} + (pab_pkg::DSR_W + 1)'(size))
                > {1'b0, page_eff};
    off_spill = off - pab_pkg::DVD_W'(div_rsp.remainder) + pab_pkg::DVD_W'(page_eff);

    blk_end   = pab_pkg::CAP_W'(off) + pab_pkg::CAP_W'(size);
    fail      = (size == '0)
             || (pab_pkg::DSR_W'(size) > page_eff)
             || (cap_prod > pab_pkg::CAP_MAX)
             || (idx >= pab_pkg::PIX_W'(pages_eff))
             || (blk_end > cap_prod);
    cursor_new = blk_end[pab_pkg::ADDR_W-1:0];
    slot_free  = !out_valid || out_ready;
    in_ready   = (state == S_IDLE);
  end

  // Configuration writes; the state is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_r <= pab_pkg::PAGE_SIZE_RST;
      max_pages_r <= pab_pkg::MAX_PAGES_RST;
      align_r     <= pab_pkg::ALIGN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pab_pkg::REG_PAGE_SIZE: page_size_r <= cfg_data;
        pab_pkg::REG_MAX_PAGES: max_pages_r <= cfg_data[pab_pkg::PAGES_W-1:0];
        pab_pkg::REG_ALIGN:     align_r     <= cfg_data[pab_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, arena state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      geo_dirty       <= 1'b1;
      div_start       <= 1'b0;
      out_valid       <= 1'b0;
      cursor          <= '0;
      page_count      <= '0;
      high_water_mark <= '0;
      overflow_total  <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // Geometry follows the registers: work it out again before the next allocation
      if (cfg_we) begin
        geo_dirty <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act  <= action;
            size <= request_size;
            if (action == pab_pkg::ACT_CLEAR) begin
              state <= S_COMMIT;
            end else if (geo_dirty) begin
              div_start    <= 1'b1;
              div_dividend <= pab_pkg::DVD_W'(p_eff);
              div_divisor  <= a_ext;
              state        <= S_GEO_DIV;
            end else begin
              div_start    <= 1'b1;
              div_dividend <= pab_pkg::DVD_W'(cursor);
              div_divisor  <= a_ext;
              state        <= S_ALIGN_DIV;
            end
          end
        end

        S_GEO_DIV: begin
          if (div_rsp.done) begin
            page_eff <= page_calc;
            state    <= S_GEO_CAP;
          end
        end

        S_GEO_CAP: begin
          cap_prod     <= pab_pkg::CAP_W'(page_eff) * pab_pkg::CAP_W'(pages_eff);
          geo_dirty    <= 1'b0;
          div_start    <= 1'b1;
          div_dividend <= pab_pkg::DVD_W'(cursor);
          div_divisor  <= a_ext;
          state        <= S_ALIGN_DIV;
        end

        S_ALIGN_DIV: begin
          // Round the cursor up, then find its page
          if (div_rsp.done) begin
            off          <= aligned;
            div_start    <= 1'b1;
            div_dividend <= aligned;
            div_divisor  <= page_eff;
            state        <= S_PAGE_DIV;
          end
        end

        S_PAGE_DIV: begin
          if (div_rsp.done) begin
            if (spill) begin
              idx <= pab_pkg::PIX_W'(div_rsp.quotient) + pab_pkg::PIX_W'(1);
              off <= off_spill;
            end else begin
              idx <= pab_pkg::PIX_W'(div_rsp.quotient);
            end
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          // Hold until the result register is free
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (act == pab_pkg::ACT_CLEAR) begin
              cursor         <= '0;
              page_count     <= '0;
              ok             <= 1'b1;
              offset         <= '0;
              page_index     <= '0;
              bytes_used     <= '0;
              pages_used     <= '0;
              high_water     <= high_water_mark;
              overflow_count <= overflow_total;
            end else if (fail) begin
              ok             <= 1'b0;
              offset         <= '0;
              page_index     <= '0;
              bytes_used     <= cursor;
              pages_used     <= page_count;
              high_water     <= high_water_mark;
              if (overflow_total != pab_pkg::OVF_SAT) begin
                overflow_total <= overflow_total + pab_pkg::OVF_W'(1);
                overflow_count <= overflow_total + pab_pkg::OVF_W'(1);
              end else begin
                overflow_count <= overflow_total;
              end
            end else begin
              cursor         <= cursor_new;
              page_count     <= pab_pkg::PAGES_W'(idx + pab_pkg::PIX_W'(1));
              ok             <= 1'b1;
              offset         <= off[pab_pkg::ADDR_W-1:0];
              page_index     <= idx[pab_pkg::IDX_W-1:0];
              bytes_used     <= cursor_new;
              pages_used     <= pab_pkg::PAGES_W'(idx + pab_pkg::PIX_W'(1));
              overflow_count <= overflow_total;
              if (cursor_new > high_water_mark) begin
                high_water_mark <= cursor_new;
                high_water      <= cursor_new;
              end else begin
                high_water      <= high_water_mark;
              end
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The cursor never passes the high-water mark
  a_cursor_hw: assert property (@(posedge clk) disable iff (rst)
    cursor <= high_water_mark)
    else $error("cursor above high-water mark");

  // A refused allocation reports no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (offset == '0 && page_index == '0))
    else $error("failed word carries a block");

  // The overflow count only grows
  a_ovf_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> overflow_total >= $past(overflow_total))
    else $error("overflow count went down");

  // The divider is started only while idle
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

/* test/pab_checker.sv */
// Checker for the paged bump allocator: predicts every result word and compares it field by field.
module pab_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pab_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic                           action,
  input  wire logic [pab_pkg::SIZE_W-1:0]     request_size,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           ok,
  input  wire logic [pab_pkg::ADDR_W-1:0]     offset,
  input  wire logic [pab_pkg::IDX_W-1:0]      page_index,
  input  wire logic [pab_pkg::ADDR_W-1:0]     bytes_used,
  input  wire logic [pab_pkg::PAGES_W-1:0]    pages_used,
  input  wire logic [pab_pkg::ADDR_W-1:0]     high_water,
  input  wire logic [pab_pkg::OVF_W-1:0]      overflow_count,
  output int unsigned                         mismatches,
  output int unsigned                         outstanding
);
  import pab_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  offset;
    logic [IDX_W-1:0]   page_index;
    logic [ADDR_W-1:0]  bytes_used;
    logic [PAGES_W-1:0] pages_used;
    logic [ADDR_W-1:0]  high_water;
    logic [OVF_W-1:0]   overflow_count;
  } grant_t;

  logic [PSZ_W-1:0]   page_size_reg = PAGE_SIZE_RST;
  logic [PAGES_W-1:0] max_pages_reg = MAX_PAGES_RST;
  logic [ALIGN_W-1:0] align_reg     = ALIGN_RST;

  logic [ADDR_W-1:0]  cursor    = '0;
  logic [PAGES_W-1:0] page_cnt  = '0;
  logic [ADDR_W-1:0]  hwm       = '0;
  logic [OVF_W-1:0]   ovf_total = '0;

  grant_t grants_due[$];

  // Apply one request word to the arena and return the result word it should produce.
  function automatic grant_t serve_word(input logic act, input logic [SIZE_W-1:0] sz);
    longint unsigned algn, pg, npages, cap, off, idx, size;
    logic granted;
    grant_t g;
    algn   = (align_reg == 0) ? 1 : align_reg;
    pg     = (page_size_reg == 0) ? 1 : page_size_reg;
    pg     = ((pg + algn - 1) / algn) * algn;
    npages = (max_pages_reg == 0) ? 1 : max_pages_reg;
    cap    = pg * npages;
    if (cap > 64'h1FFF_FFFF) cap = 0;
    size = sz;
    off  = ((cursor + algn - 1) / algn) * algn;
    idx  = off / pg;
    // A block that would cross the page end starts the next page instead.
    if (off + size > (idx + 1) * pg) begin
      idx = idx + 1;
      off = idx * pg;
    end
    granted = (size != 0) && (size <= pg) && (cap != 0) && (idx < npages) &&
              (size <= cap) && (off <= cap - size);
    g = '0;
    if (act == ACT_CLEAR) begin
      cursor   = '0;
      page_cnt = '0;
      g.ok     = 1'b1;
    end else if (granted) begin
      cursor   = ADDR_W'(off + size);
      page_cnt = PAGES_W'(idx + 1);
      if (cursor > hwm) hwm = cursor;
      g.ok         = 1'b1;
      g.offset     = ADDR_W'(off);
      g.page_index = IDX_W'(idx);
    end else if (ovf_total != OVF_SAT) begin
      ovf_total = ovf_total + 1;
    end
    g.bytes_used     = cursor;
    g.pages_used     = page_cnt;
    g.high_water     = hwm;
    g.overflow_count = ovf_total;
    return g;
  endfunction

  function automatic int unsigned field_bad(input string fname, input logic [31:0] want,
                                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      page_size_reg = PAGE_SIZE_RST;
      max_pages_reg = MAX_PAGES_RST;
      align_reg     = ALIGN_RST;
      cursor        = '0;
      page_cnt      = '0;
      hwm           = '0;
      ovf_total     = '0;
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGE_SIZE: page_size_reg = cfg_data;
          REG_MAX_PAGES: max_pages_reg = cfg_data[PAGES_W-1:0];
          REG_ALIGN:     align_reg     = cfg_data[ALIGN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        grants_due.insert(grants_due.size(), serve_word(action, request_size));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result word with none outstanding, expected nothing got ok=%0d",
                   $time, ok);
          mismatches = mismatches + 1;
        end else begin
          want = grants_due.pop_front();
          mismatches = mismatches
            + field_bad("ok", want.ok, ok)
            + field_bad("offset", want.offset, offset)
            + field_bad("page_index", want.page_index, page_index)
            + field_bad("bytes_used", want.bytes_used, bytes_used)
            + field_bad("pages_used", want.pages_used, pages_used)
            + field_bad("high_water", want.high_water, high_water)
            + field_bad("overflow_count", want.overflow_count, overflow_count);
        end
      end
    end
    outstanding <= grants_due.size();
  end

endmodule

/* test/tb_paged_aligned_bump_allocator.sv */
// Testbench top for the paged bump allocator: clock, reset, stimulus, stalls and verdict.
module tb_paged_aligned_bump_allocator;
  import pab_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int unsigned HOLD_OFF       = 300;   // long receiver back-pressure stretch
  localparam int unsigned PHASES         = 12;
  localparam int unsigned PHASE_WORDS    = 88;
  localparam int unsigned FILL_PAGES     = 40;    // pages in the fill sweep arena

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_PAGE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  action       = ACT_ALLOC;
  logic [SIZE_W-1:0]     request_size = '0;
  logic                  out_ready    = 1'b0;

  logic                  in_ready;
  logic                  out_valid;
  logic                  ok;
  logic [ADDR_W-1:0]     offset;
  logic [IDX_W-1:0]      page_index;
  logic [ADDR_W-1:0]     bytes_used;
  logic [PAGES_W-1:0]    pages_used;
  logic [ADDR_W-1:0]     high_water;
  logic [OVF_W-1:0]      overflow_count;

  int unsigned mismatches;
  int unsigned outstanding;

  // Stall knobs: the sender's idle odds are read only by the stimulus process,
  // the receiver's are handed over with nonblocking writes.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req     = 0;
  int unsigned arena_psz    = 65536;  // page size last written, to shape request sizes
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  paged_aligned_bump_allocator u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .request_size   (request_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .offset         (offset),
    .page_index     (page_index),
    .bytes_used     (bytes_used),
    .pages_used     (pages_used),
    .high_water     (high_water),
    .overflow_count (overflow_count)
  );

  pab_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .request_size   (request_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .offset         (offset),
    .page_index     (page_index),
    .bytes_used     (bytes_used),
    .pages_used     (pages_used),
    .high_water     (high_water),
    .overflow_count (overflow_count),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Receiver: stall at random, or hold off for a whole stretch when the
  // stimulus asks for one, so the allocator backs up and drops in_ready.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: give up after too long without a word moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, idling first at the current odds, and hold it
  // until the allocator takes it. Returns on the accepting edge.
  task automatic send_word(input logic act, input logic [SIZE_W-1:0] sz);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    request_size <= sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every result word has been checked off.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges. The 13-bit registers get
  // junk in the unused upper bits of the data bus, which must be dropped.
  task automatic set_arena(input int unsigned psz, input int unsigned np,
                           input int unsigned al);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PAGE_SIZE;
    cfg_data  <= CFG_DATA_W'(psz);
    @(posedge clk);
    cfg_index <= REG_MAX_PAGES;
    cfg_data  <= CFG_DATA_W'(($urandom_range(0, 15) << PAGES_W) | (np & 32'h1FFF));
    @(posedge clk);
    cfg_index <= REG_ALIGN;
    cfg_data  <= CFG_DATA_W'(($urandom_range(0, 15) << ALIGN_W) | (al & 32'h1FFF));
    @(posedge clk);
    cfg_we    <= 1'b0;
    arena_psz = psz;
  endtask

  // Pick an arena: small ones fill up fast, wide ones spread over many pages,
  // and the extremes hit zero registers, full-width values and capacity overflow.
  task automatic random_arena(input int unsigned kind);
    int unsigned psz_x[4];
    int unsigned np_x[4];
    int unsigned al_x[5];
    psz_x = '{0, 1, 65536, 131071};
    np_x  = '{0, 1, 4096, 8191};
    al_x  = '{0, 1, 4095, 4096, 8191};
    case (kind)
      0: set_arena($urandom_range(1, 300), $urandom_range(1, 8),
                   $urandom_range(1, 4) << $urandom_range(0, 5));
      1: set_arena($urandom_range(1, 65536), $urandom_range(1, 64),
                   $urandom_range(1, 4096));
      default: set_arena(psz_x[$urandom_range(0, 3)], np_x[$urandom_range(0, 3)],
                         al_x[$urandom_range(0, 4)]);
    endcase
  endtask

  // One random word: mostly frames of allocations sized around the page,
  // with clears, zero sizes, oversize requests and full-range junk mixed in.
  task automatic random_word();
    int unsigned pick;
    int unsigned psz_eff;
    logic [SIZE_W-1:0] sz;
    pick    = $urandom_range(0, 99);
    psz_eff = (arena_psz == 0) ? 1 : arena_psz;
    if (pick < 7) begin
      send_word(ACT_CLEAR, SIZE_W'($urandom));
    end else begin
      if (pick < 10)      sz = '0;
      else if (pick < 15) sz = SIZE_W'($urandom);
      else if (pick < 22) sz = SIZE_W'(arena_psz);
      else if (pick < 26) sz = SIZE_W'(arena_psz + 1);
      else if (pick < 60) sz = SIZE_W'($urandom_range(1, psz_eff / 4 + 1));
      else                sz = SIZE_W'($urandom_range(1, psz_eff));
      send_word(ACT_ALLOC, sz);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset arena (64 KiB pages, 16 pages, 256-byte alignment): zero size,
    // exact page, oversize, page crossing, and a clear carrying a junk size.
    send_word(ACT_ALLOC, 17'd0);
    send_word(ACT_ALLOC, 17'd1);
    send_word(ACT_ALLOC, 17'd131071);
    send_word(ACT_ALLOC, 17'd65536);
    send_word(ACT_ALLOC, 17'd65537);
    send_word(ACT_ALLOC, 17'd300);
    send_word(ACT_CLEAR, 17'd131071);
    send_word(ACT_ALLOC, 17'd65536);

    // Zero registers behave as one: a single one-byte page.
    settle();
    set_arena(0, 0, 0);
    send_word(ACT_ALLOC, 17'd1);
    send_word(ACT_ALLOC, 17'd1);
    send_word(ACT_ALLOC, 17'd2);

    // Page size rounded up to the alignment, spill to the next page, run off the end.
    settle();
    set_arena(100, 3, 64);
    send_word(ACT_ALLOC, 17'd50);
    send_word(ACT_ALLOC, 17'd100);
    send_word(ACT_ALLOC, 17'd128);
    send_word(ACT_ALLOC, 17'd1);
    send_word(ACT_CLEAR, 17'd0);

    // Capacity past 29 bits refuses everything; a large one that fits still grants.
    settle();
    set_arena(131071, 8191, 8191);
    send_word(ACT_ALLOC, 17'd1);
    settle();
    set_arena(65536, 4096, 4096);
    send_word(ACT_ALLOC, 17'd65536);
    send_word(ACT_ALLOC, 17'd4096);

    // Random phases, rotating through the idle mixes; hold the receiver off
    // now and then while the sender keeps pushing, and pause once mid-phase
    // until everything outstanding has come back.
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      random_arena(p % 3);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 86; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 86; end
        default: begin tx_idle_pct = 20; rx_stall_pct <= 20; end
      endcase
      for (int unsigned w = 0; w < PHASE_WORDS; w++) begin
        if (p % 4 == 0 && p != 0 && w == 20) hold_req <= hold_req + 1;
        if (p == 2 && w == PHASE_WORDS / 2) settle();
        random_word();
      end
    end

    // Fill sweep: one near-full page per word, each starting the next page,
    // until the last word runs off the end of the arena.
    settle();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    set_arena(65536, FILL_PAGES, 4096);
    for (int unsigned w = 0; w <= FILL_PAGES; w++)
      send_word(ACT_ALLOC, SIZE_W'(65536 - $urandom_range(0, 4095)));
    send_word(ACT_CLEAR, 17'd0);

    settle();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pab_pkg.sv
rtl/pab_divider.sv
rtl/paged_aligned_bump_allocator.sv
test/pab_checker.sv
test/tb_paged_aligned_bump_allocator.sv
